### design/dchm_pkg.sv
// ----------------------------------------------------------------------------
// dchm_pkg
// Shared types and constants of the duty-cycle histogram monitor: the item
// and result payloads, the item kinds, the register indexes and the
// classified command that travels from the front to the back.
// ----------------------------------------------------------------------------
package dchm_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [6:0] PCT_FULL = 7'd100;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_BOUNDARY = 2'd1,
        KIND_CLEAR    = 2'd2,
        KIND_UNUSED   = 2'd3
    } kind_t;

    typedef enum logic [0:0] {
        REG_PERIOD_TICKS = 1'b0,
        REG_ENABLE       = 1'b1
    } reg_index_t;

    typedef struct packed {
        kind_t       kind;
        logic        awake;
        logic [3:0]  bin_select;
    } item_t;

    typedef struct packed {
        logic        recorded;
        logic [6:0]  last_usage;
        logic [6:0]  top_usage;
        logic        stats_known;
        logic [31:0] bin_count;
        logic        measuring;
    } result_t;

    typedef struct packed {
        kind_t       op;
        logic        awake;
        logic        sel_ok;
        logic [3:0]  sel;
    } cmd_t;

endpackage

### design/duty_cycle_histogram_monitor.sv
// ----------------------------------------------------------------------------
// duty_cycle_histogram_monitor
// Measures the busy duty cycle over fixed periods and keeps a histogram of
// the per-period usage together with the peak usage since the last clear.
//
//   Channel   Direction  Handshake                    Payload
//   item      in         item_valid / item_ready      item_t
//   result    out        result_valid / result_ready  result_t
//   cfg       in         cfg_we, cfg_index            cfg_data (32 bits)
//
// Ticks, clears, unused kinds and boundaries with no running measurement
// are taken back to back unless the result side stalls, and each passes
// through the read stage and the output register. A boundary that closes
// a measurement holds the back end until the shift-subtract divider in the
// usage unit, which retires one quotient bit per cycle, has settled.
// Reset clears all control state and the histogram valid bits at once.
// A two-entry command queue and a result register let either side stall.
// ----------------------------------------------------------------------------
module duty_cycle_histogram_monitor
    import dchm_pkg::*;
#(
    parameter int BINS        = 10,
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_we,
    input  reg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    dchm_front #(
        .BINS (BINS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    dchm_back #(
        .BINS        (BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### design/dchm_usage.sv
// ----------------------------------------------------------------------------
// dchm_usage
// Usage percentage unit. Computes min(100, (busy*100 + period/2) / period)
// with a registered constant multiply, a rounding add, an overflow check and
// a shift-subtract divider that settles one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dchm_usage
    import dchm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] busy,
    input  logic [31:0] period,
    output logic        done,
    output logic [6:0]  usage
);

    localparam int PROD_W = 39;
    localparam int NUM_W  = 40;
    localparam int Q_W    = 8;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_ADD,
        U_CHECK,
        U_DIV,
        U_DONE
    } state_t;

    state_t              state_reg;
    logic [31:0]         busy_reg;
    logic [31:0]         per_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [NUM_W-1:0]    rem_reg;
    logic [Q_W-1:0]      q_reg;
    logic [2:0]          cnt_reg;
    logic [NUM_W-1:0]    trial;
    logic [NUM_W-1:0]    limit;

    assign trial = NUM_W'(per_reg) << cnt_reg;
    assign limit = {per_reg, {Q_W{1'b0}}};

    assign done  = (state_reg == U_DONE);
    assign usage = (q_reg > Q_W'(PCT_FULL)) ? PCT_FULL : q_reg[6:0];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= U_IDLE;
            busy_reg  <= '0;
            per_reg   <= 32'd1;
            prod_reg  <= '0;
            rem_reg   <= '0;
            q_reg     <= '0;
            cnt_reg   <= '0;
        end
        else begin
            unique case (state_reg)
                U_IDLE:
                begin
                    if (start) begin
                        busy_reg  <= busy;
                        per_reg   <= (period == 32'd0) ? 32'd1 : period;
                        state_reg <= U_MUL;
                    end
                end
                U_MUL:
                begin
                    prod_reg  <= PROD_W'(busy_reg) * PROD_W'(PCT_FULL);
                    state_reg <= U_ADD;
                end
                U_ADD:
                begin
                    rem_reg   <= NUM_W'(prod_reg) + NUM_W'(per_reg >> 1);
                    q_reg     <= '0;
                    state_reg <= U_CHECK;
                end
                U_CHECK:
                begin
                    if (rem_reg >= limit) begin
                        q_reg     <= '1;
                        state_reg <= U_DONE;
                    end
                    else begin
                        cnt_reg   <= 3'(Q_W - 1);
                        state_reg <= U_DIV;
                    end
                end
                U_DIV:
                begin
                    if (rem_reg >= trial) begin
                        rem_reg        <= rem_reg - trial;
                        q_reg[cnt_reg] <= 1'b1;
                    end
                    if (cnt_reg == 3'd0) begin
                        state_reg <= U_DONE;
                    end
                    else begin
                        cnt_reg <= cnt_reg - 3'd1;
                    end
                end
                U_DONE:
                begin
                    state_reg <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

endmodule

### design/dchm_front.sv
// ----------------------------------------------------------------------------
// dchm_front
// Front end. Accepts items, decodes the kind and range-checks the selected
// bin, and holds the classified commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module dchm_front
    import dchm_pkg::*;
#(
    parameter int BINS = 10
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  item_t item,
    output logic  cmd_valid,
    output cmd_t  cmd,
    input  logic  cmd_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t               queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    cmd_t               cmd_in;
    logic               push;

    always_comb begin
        cmd_in.op     = item.kind;
        cmd_in.awake  = item.awake;
        cmd_in.sel    = item.bin_select;
        cmd_in.sel_ok = (5'(item.bin_select) < 5'(BINS));
    end

    assign item_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = item_valid && item_ready;
    assign cmd_valid  = (count_reg != '0);
    assign cmd        = queue_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !cmd_pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cmd_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

### design/dchm_back.sv
// ----------------------------------------------------------------------------
// dchm_back
// Back end. Executes classified commands: counts busy ticks, closes a
// measurement through the usage unit, updates the histogram memory and the
// peak, and returns one result per command through a read stage and an
// output register.
// ----------------------------------------------------------------------------
module dchm_back
    import dchm_pkg::*;
#(
    parameter int BINS        = 10,
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_pop,
    input  logic                  cfg_we,
    input  reg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result
);

    localparam int AW = $clog2(BINS);
    localparam int SCALED_W = 11;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CALC,
        B_WRITE,
        B_FINISH
    } state_t;

    state_t                 state_reg, state_next;
    logic [31:0]            period_reg;
    logic                   enable_reg;
    logic [31:0]            busy_reg, busy_next;
    logic                   running_reg, running_next;
    logic [6:0]             peak_reg, peak_next;
    logic [BINS-1:0]        bin_vld_reg, bin_vld_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic                   zero_reg, zero_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [6:0]             usage_reg, usage_next;

    logic                   p_valid_reg, p_valid_next;
    logic                   p_rec_reg, p_rec_next;
    logic [6:0]             p_last_reg, p_last_next;
    logic [6:0]             p_max_reg, p_max_next;
    logic                   p_meas_reg, p_meas_next;
    logic                   p_zero_reg, p_zero_next;

    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;

    logic [COUNT_WIDTH-1:0] bins_mem [BINS];
    logic [COUNT_WIDTH-1:0] rda_reg, rdb_reg;
    logic                   vlda_reg, vldb_reg;
    logic [COUNT_WIDTH-1:0] bin_old, bin_inc, bin_val;

    logic                   p_adv, p_free;
    logic [AW-1:0]          sel_addr, rda_addr, idx_c;
    logic                   rda_en, rdb_en, bin_we;
    logic                   calc_start, calc_done;
    logic [6:0]             calc_usage;
    logic [SCALED_W-1:0]    scaled;

    dchm_usage u_usage (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (calc_start),
        .busy   (busy_reg),
        .period (period_reg),
        .done   (calc_done),
        .usage  (calc_usage)
    );

    assign p_adv    = p_valid_reg && (!out_valid_reg || result_ready);
    assign p_free   = !p_valid_reg || p_adv;
    assign sel_addr = cmd.sel_ok ? cmd.sel[AW-1:0] : '0;
    assign rda_addr = (state_reg == B_FINISH) ? addr_reg : sel_addr;

    always_comb begin
        scaled = SCALED_W'(calc_usage) * SCALED_W'(BINS);
        idx_c  = '0;
        for (int k = 1; k < BINS; k++) begin
            if (scaled >= SCALED_W'(k * 100)) begin
                idx_c = AW'(k);
            end
        end
    end

    assign bin_old = vldb_reg ? rdb_reg : '0;
    assign bin_inc = (bin_old == '1) ? bin_old : bin_old + 1'b1;
    assign bin_val = (p_zero_reg || !vlda_reg) ? '0 : rda_reg;

    always_comb begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        running_next   = running_reg;
        peak_next      = peak_reg;
        bin_vld_next   = bin_vld_reg;
        addr_next      = addr_reg;
        zero_next      = zero_reg;
        idx_next       = idx_reg;
        usage_next     = usage_reg;
        p_valid_next   = p_adv ? 1'b0 : p_valid_reg;
        p_rec_next     = p_rec_reg;
        p_last_next    = p_last_reg;
        p_max_next     = p_max_reg;
        p_meas_next    = p_meas_reg;
        p_zero_next    = p_zero_reg;
        cmd_pop        = 1'b0;
        calc_start     = 1'b0;
        rda_en         = 1'b0;
        rdb_en         = 1'b0;
        bin_we         = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid) begin
                    if (cmd.op == KIND_BOUNDARY && running_reg) begin
                        cmd_pop    = 1'b1;
                        calc_start = 1'b1;
                        addr_next  = sel_addr;
                        zero_next  = !cmd.sel_ok;
                        state_next = B_CALC;
                    end
                    else if (p_free) begin
                        cmd_pop      = 1'b1;
                        rda_en       = 1'b1;
                        p_valid_next = 1'b1;
                        p_rec_next   = 1'b0;
                        p_last_next  = '0;
                        p_zero_next  = !cmd.sel_ok;
                        case (cmd.op)
                            KIND_TICK:
                            begin
                                if (cmd.awake && busy_reg != '1) begin
                                    busy_next = busy_reg + 32'd1;
                                end
                            end
                            KIND_BOUNDARY:
                            begin
                                if (enable_reg) begin
                                    busy_next    = '0;
                                    running_next = 1'b1;
                                end
                            end
                            KIND_CLEAR:
                            begin
                                running_next = 1'b0;
                                peak_next    = '0;
                                bin_vld_next = '0;
                                p_zero_next  = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                        p_max_next  = peak_next;
                        p_meas_next = running_next;
                    end
                end
            end
            B_CALC:
            begin
                if (calc_done) begin
                    usage_next = calc_usage;
                    idx_next   = idx_c;
                    rdb_en     = 1'b1;
                    state_next = B_WRITE;
                end
            end
            B_WRITE:
            begin
                bin_we                = 1'b1;
                bin_vld_next[idx_reg] = 1'b1;
                if (usage_reg > peak_reg) begin
                    peak_next = usage_reg;
                end
                running_next = enable_reg;
                if (enable_reg) begin
                    busy_next = '0;
                end
                state_next = B_FINISH;
            end
            B_FINISH:
            begin
                if (p_free) begin
                    rda_en       = 1'b1;
                    p_valid_next = 1'b1;
                    p_rec_next   = 1'b1;
                    p_last_next  = usage_reg;
                    p_max_next   = peak_reg;
                    p_meas_next  = running_reg;
                    p_zero_next  = zero_reg;
                    state_next   = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (p_adv) begin
            out_valid_next        = 1'b1;
            out_next.recorded     = p_rec_reg;
            out_next.last_usage   = p_last_reg;
            out_next.top_usage    = p_max_reg;
            out_next.stats_known  = (p_max_reg != '0);
            out_next.bin_count    = 32'(bin_val);
            out_next.measuring    = p_meas_reg;
        end
        else if (result_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (bin_we) begin
            bins_mem[idx_reg] <= bin_inc;
        end
        if (rda_en) begin
            rda_reg  <= bins_mem[rda_addr];
            vlda_reg <= bin_vld_reg[rda_addr];
        end
        if (rdb_en) begin
            rdb_reg  <= bins_mem[idx_c];
            vldb_reg <= bin_vld_reg[idx_c];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= B_IDLE;
            period_reg    <= 32'd100000;
            enable_reg    <= 1'b0;
            busy_reg      <= '0;
            running_reg   <= 1'b0;
            peak_reg      <= '0;
            bin_vld_reg   <= '0;
            addr_reg      <= '0;
            zero_reg      <= 1'b0;
            idx_reg       <= '0;
            usage_reg     <= '0;
            p_valid_reg   <= 1'b0;
            p_rec_reg     <= 1'b0;
            p_last_reg    <= '0;
            p_max_reg     <= '0;
            p_meas_reg    <= 1'b0;
            p_zero_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            running_reg   <= running_next;
            peak_reg      <= peak_next;
            bin_vld_reg   <= bin_vld_next;
            addr_reg      <= addr_next;
            zero_reg      <= zero_next;
            idx_reg       <= idx_next;
            usage_reg     <= usage_next;
            p_valid_reg   <= p_valid_next;
            p_rec_reg     <= p_rec_next;
            p_last_reg    <= p_last_next;
            p_max_reg     <= p_max_next;
            p_meas_reg    <= p_meas_next;
            p_zero_reg    <= p_zero_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_PERIOD_TICKS: period_reg <= cfg_data;
                    REG_ENABLE:       enable_reg <= cfg_data[0];
                    default:          enable_reg <= enable_reg;
                endcase
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### design/dchm_checker.sv
// ----------------------------------------------------------------------------
// dchm_checker
// Port-level checks of the duty-cycle histogram monitor, attached to the
// top level by a bind statement.
// ----------------------------------------------------------------------------
module dchm_checker
    import dchm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // A stalled result stays put until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.stats_known == (result.top_usage != 7'd0))
        else $error("stats_known does not match top_usage");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.recorded |-> result.last_usage == 7'd0)
        else $error("usage reported on a request that recorded nothing");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.recorded |->
            result.last_usage <= result.top_usage && result.top_usage <= PCT_FULL)
        else $error("recorded usage exceeds the peak or full scale");

endmodule

bind duty_cycle_histogram_monitor dchm_checker u_dchm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Duty-cycle histogram monitor testbench
// Drives tick, boundary, clear and unused requests through the item channel
// and writes the period and enable registers between phases while the block
// is idle. Every accepted request is run through a behavioral model of the
// monitor, and each result is checked field by field against the oldest
// prediction. A short directed part covers the reset defaults, rounding,
// clamping, a zero period, a cleared enable and the clear request. Random
// phases follow, with mostly well-formed measurement periods, under no
// idling, sender gaps, receiver stalls and both together.
// ----------------------------------------------------------------------------
module testbench
    import dchm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BIN_COUNT   = 10;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTS = 10;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_ready;
    item_t                 item = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  cfg_we = 1'b0;
    reg_index_t            cfg_index = REG_PERIOD_TICKS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [31:0] period_reg;
    logic        enable_reg;
    logic [31:0] busy_ticks;
    logic        measuring_now;
    logic [6:0]  peak_pct;
    logic [31:0] bin_tally [BIN_COUNT];

    result_t     pending_results [$];
    result_t     oldest;
    int          mismatches = 0;
    int          cycles = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;

    duty_cycle_histogram_monitor #(
        .BINS        (BIN_COUNT),
        .COUNT_WIDTH (32)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= stall_pct);
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result %p", result);
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (result.recorded !== oldest.recorded
                    || result.last_usage !== oldest.last_usage
                    || result.top_usage !== oldest.top_usage
                    || result.stats_known !== oldest.stats_known
                    || result.bin_count !== oldest.bin_count
                    || result.measuring !== oldest.measuring)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch at cycle %0d: expected %p, got %p",
                                 cycles, oldest, result);
                end
            end
        end
    end

    function automatic void reset_monitor_model();
        period_reg    = 32'd100000;
        enable_reg    = 1'b0;
        busy_ticks    = '0;
        measuring_now = 1'b0;
        peak_pct      = '0;
        for (int i = 0; i < BIN_COUNT; i++)
            bin_tally[i] = '0;
    endfunction

    function automatic result_t advance_monitor(item_t it);
        result_t         r;
        longint unsigned div;
        longint unsigned quotient;
        logic [6:0]      pct;
        int unsigned     slot;
        r = '0;
        case (it.kind)
            KIND_TICK:
            begin
                if (it.awake && busy_ticks != 32'hFFFF_FFFF)
                    busy_ticks = busy_ticks + 1;
            end
            KIND_BOUNDARY:
            begin
                if (measuring_now)
                begin
                    div = (period_reg == 0) ? 64'd1 : {32'd0, period_reg};
                    quotient = ({32'd0, busy_ticks} * 64'd100 + div / 2) / div;
                    pct = (quotient > 100) ? PCT_FULL : quotient[6:0];
                    slot = pct * BIN_COUNT / 100;
                    if (slot >= BIN_COUNT)
                        slot = BIN_COUNT - 1;
                    if (bin_tally[slot] != 32'hFFFF_FFFF)
                        bin_tally[slot] = bin_tally[slot] + 1;
                    if (pct > peak_pct)
                        peak_pct = pct;
                    r.recorded   = 1'b1;
                    r.last_usage = pct;
                    measuring_now = 1'b0;
                end
                if (enable_reg)
                begin
                    busy_ticks    = '0;
                    measuring_now = 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                measuring_now = 1'b0;
                peak_pct      = '0;
                for (int i = 0; i < BIN_COUNT; i++)
                    bin_tally[i] = '0;
            end
            default:
            begin
            end
        endcase
        r.top_usage   = peak_pct;
        r.stats_known = (peak_pct != 0);
        r.bin_count   = (it.bin_select < BIN_COUNT) ? bin_tally[it.bin_select] : '0;
        r.measuring   = measuring_now;
        return r;
    endfunction

    task automatic send_event(kind_t k, logic aw, logic [3:0] sel);
        item_t it;
        it = '{kind: k, awake: aw, bin_select: sel};
        while ($urandom_range(99) < gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do
        begin
            @(posedge clk);
        end
        while (!item_ready);
        pending_results.push_back(advance_monitor(it));
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure(logic [31:0] period, logic on);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= REG_PERIOD_TICKS;
        cfg_data  <= period;
        @(posedge clk);
        period_reg = period;
        cfg_index <= REG_ENABLE;
        cfg_data  <= {31'd0, on};
        @(posedge clk);
        enable_reg = on;
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_event(KIND_TICK, 1'b1, 4'd0);
        send_event(KIND_BOUNDARY, 1'b0, 4'd9);
        send_event(KIND_UNUSED, 1'b1, 4'd15);
        send_event(KIND_TICK, 1'b1, 4'd10);
    endtask

    task automatic test_usage_rounding();
        configure(32'd4, 1'b1);
        send_event(KIND_BOUNDARY, 1'b0, 4'd0);
        send_event(KIND_TICK, 1'b1, 4'd7);
        send_event(KIND_TICK, 1'b1, 4'd7);
        send_event(KIND_TICK, 1'b0, 4'd7);
        send_event(KIND_TICK, 1'b1, 4'd7);
        send_event(KIND_BOUNDARY, 1'b0, 4'd7);
    endtask

    task automatic test_zero_period();
        configure(32'd0, 1'b1);
        send_event(KIND_TICK, 1'b1, 4'd9);
        send_event(KIND_TICK, 1'b1, 4'd9);
        send_event(KIND_BOUNDARY, 1'b1, 4'd9);
    endtask

    task automatic test_enable_cleared();
        configure(32'hFFFF_FFFF, 1'b0);
        send_event(KIND_TICK, 1'b1, 4'd0);
        send_event(KIND_BOUNDARY, 1'b0, 4'd0);
        send_event(KIND_TICK, 1'b1, 4'd0);
        send_event(KIND_BOUNDARY, 1'b1, 4'd15);
    endtask

    task automatic test_clear();
        configure(32'd1, 1'b1);
        send_event(KIND_BOUNDARY, 1'b0, 4'd9);
        send_event(KIND_TICK, 1'b1, 4'd9);
        send_event(KIND_CLEAR, 1'b1, 4'd9);
        send_event(KIND_BOUNDARY, 1'b0, 4'd9);
        send_event(KIND_TICK, 1'b1, 4'd9);
        send_event(KIND_BOUNDARY, 1'b0, 4'd9);
    endtask

    task automatic test_random_traffic(int gaps, int stalls, int total);
        int          sent;
        int          run_len;
        int          awake_pct;
        logic [31:0] period;
        logic [3:0]  sel;
        gap_pct   = gaps;
        stall_pct = stalls;
        for (int part = 0; part < 3; part++)
        begin
            case ($urandom_range(7))
                0: period = 32'd0;
                1: period = 32'd1;
                2: period = 32'hFFFF_FFFF;
                3: period = $urandom;
                default: period = $urandom_range(2, 24);
            endcase
            configure(period, $urandom_range(9) != 0);
            sent = 0;
            while (sent < total / 3)
            begin
                sel = ($urandom_range(99) < 85) ? 4'($urandom_range(9))
                                                : 4'($urandom_range(10, 15));
                case ($urandom_range(99)) inside
                    [0:79]:
                    begin
                        send_event(KIND_BOUNDARY, 1'($urandom_range(1)), sel);
                        sent++;
                        if (period_reg <= 1)
                            run_len = $urandom_range(4);
                        else if (period_reg <= 40)
                            run_len = $urandom_range(period_reg + 4);
                        else
                            run_len = $urandom_range(40);
                        awake_pct = $urandom_range(100);
                        for (int i = 0; i < run_len; i++)
                        begin
                            sel = ($urandom_range(99) < 85) ? 4'($urandom_range(9))
                                                            : 4'($urandom_range(10, 15));
                            send_event(KIND_TICK, $urandom_range(99) < awake_pct, sel);
                            sent++;
                        end
                    end
                    [80:87]:
                    begin
                        send_event(KIND_CLEAR, 1'($urandom_range(1)), sel);
                        sent++;
                    end
                    [88:92]:
                    begin
                        send_event(KIND_UNUSED, 1'($urandom_range(1)), sel);
                        sent++;
                    end
                    [93:96]:
                    begin
                        send_event(kind_t'($urandom_range(3)), 1'($urandom_range(1)),
                                   4'($urandom_range(15)));
                        sent++;
                    end
                    default:
                    begin
                        wait_drained();
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        reset_monitor_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_usage_rounding();
        test_zero_period();
        test_enable_cleared();
        test_clear();
        test_random_traffic(0, 0, 360);
        test_random_traffic(59, 0, 360);
        test_random_traffic(0, 59, 360);
        test_random_traffic(18, 18, 370);
        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
